// ===== rtl/core/lbs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbs_pkg
// shared constants and types of the longest bitonic subsequence core
// ----------------------------------------------------------------------------
package lbs_pkg;

    localparam int LBS_MAX_LEN    = 256;
    localparam int LBS_VALUE_BITS = 16;
    localparam int VALUE_W        = 16;
    localparam int LENGTH_W       = 9;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RDP,
        S_LDP,
        S_SCAN,
        S_WR
    } t_state;

    typedef struct packed {
        logic val_we;
        logic dp_we;
    } t_mem_ctl;

endpackage

// ===== rtl/core/longest_bitonic_subsequence_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// longest_bitonic_subsequence_core
// loads a set of values and returns the length of its longest bitonic
// subsequence
// ----------------------------------------------------------------------------
// An element transfers at a rising edge with i_start high and o_busy low.
// Elements are stored in order; those arriving while MAX_LEN are already
// stored are dropped and flag overflow. An element with i_last high closes
// the set: o_busy rises and the table is filled from the right end.
// For position p the core reads value[p] (states S_RDP and S_LDP), then
// streams entries p+1 .. n-1 out of the memories one per cycle and writes
// its table entry (state S_WR); the run time after the closing transfer is
// set by the single read port of the memories.
// The result sits on o_length and o_overflow for one cycle with o_done high,
// in the cycle that o_busy falls; the receiver cannot stall it. Element
// count and overflow then clear and a new set may start at once.
// Synchronous reset empties the set and returns to idle; memory contents
// are not cleared, as only stored entries are ever read.
// ----------------------------------------------------------------------------
module longest_bitonic_subsequence_core
    import lbs_pkg::*;
#(
    parameter int MAX_LEN    = LBS_MAX_LEN,
    parameter int VALUE_BITS = LBS_VALUE_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  logic [VALUE_W-1:0]  i_value,
    input  logic                i_last,
    output logic                o_done,
    output logic [LENGTH_W-1:0] o_length,
    output logic                o_overflow
);

    localparam int SW    = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
    localparam int IDX_W = $clog2(MAX_LEN);
    localparam int CNT_W = $clog2(MAX_LEN + 1);
    localparam int LEN_W = $clog2(MAX_LEN + 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(MAX_LEN);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_ovf, n_ovf;
    logic [IDX_W-1:0]   r_p, n_p;
    logic [CNT_W-1:0]   r_q, n_q;
    logic [SW-1:0]      r_vp, n_vp;
    logic [LEN_W-1:0]   r_dn, n_dn;
    logic [LEN_W-1:0]   r_bt, n_bt;
    logic [LEN_W-1:0]   r_best, n_best;
    logic               r_done, n_done;
    logic [LENGTH_W-1:0] r_length, n_length;
    logic               r_overflow, n_overflow;

    t_mem_ctl           mem_ctl;
    logic [IDX_W-1:0]   raddr;
    logic [SW-1:0]      val_rdata;
    logic [LEN_W-1:0]   fall_rdata;
    logic [LEN_W-1:0]   best_rdata;
    logic [LEN_W-1:0]   fall_inc;
    logic [LEN_W-1:0]   best_inc;
    logic [LEN_W-1:0]   bt_final;
    logic [LEN_W-1:0]   best_max;
    logic               accept;

    assign accept   = i_start && (r_state == S_IDLE);
    assign fall_inc = fall_rdata + LEN_W'(1);
    assign best_inc = best_rdata + LEN_W'(1);
    assign bt_final = (r_bt < r_dn) ? r_dn : r_bt;
    assign best_max = (bt_final > r_best) ? bt_final : r_best;

    lbs_dp_mem #(
        .DEPTH  (MAX_LEN),
        .DATA_W (SW),
        .LEN_W  (LEN_W)
    ) u_mem (
        .i_clk        (i_clk),
        .i_ctl        (mem_ctl),
        .i_val_waddr  (r_count[IDX_W-1:0]),
        .i_val_wdata  (i_value[SW-1:0]),
        .i_dp_waddr   (r_p),
        .i_fall_wdata (r_dn),
        .i_best_wdata (bt_final),
        .i_raddr      (raddr),
        .o_val_rdata  (val_rdata),
        .o_fall_rdata (fall_rdata),
        .o_best_rdata (best_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p        <= n_p;
        r_q        <= n_q;
        r_vp       <= n_vp;
        r_dn       <= n_dn;
        r_bt       <= n_bt;
        r_best     <= n_best;
        r_length   <= n_length;
        r_overflow <= n_overflow;
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_ovf      = r_ovf;
        n_p        = r_p;
        n_q        = r_q;
        n_vp       = r_vp;
        n_dn       = r_dn;
        n_bt       = r_bt;
        n_best     = r_best;
        n_done     = 1'b0;
        n_length   = r_length;
        n_overflow = r_overflow;
        mem_ctl    = '0;
        raddr      = r_q[IDX_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (r_count != FULL) begin
                        mem_ctl.val_we = 1'b1;
                        n_count        = r_count + CNT_W'(1);
                        n_p            = r_count[IDX_W-1:0];
                    end else begin
                        n_ovf = 1'b1;
                        n_p   = IDX_W'(r_count - CNT_W'(1));
                    end
                    if (i_last) begin
                        n_best  = '0;
                        n_state = S_RDP;
                    end
                end
            end
            S_RDP: begin
                raddr   = r_p;
                n_q     = CNT_W'(r_p) + CNT_W'(1);
                n_state = S_LDP;
            end
            S_LDP: begin
                n_vp = val_rdata;
                n_dn = LEN_W'(1);
                n_bt = LEN_W'(1);
                if (r_q < r_count) begin
                    n_q     = r_q + CNT_W'(1);
                    n_state = S_SCAN;
                end else begin
                    n_state = S_WR;
                end
            end
            S_SCAN: begin
                // data on the read port belongs to entry r_q - 1
                if (val_rdata < r_vp && fall_inc > r_dn) begin
                    n_dn = fall_inc;
                end
                if (val_rdata > r_vp && best_inc > r_bt) begin
                    n_bt = best_inc;
                end
                if (r_q < r_count) begin
                    n_q = r_q + CNT_W'(1);
                end else begin
                    n_state = S_WR;
                end
            end
            S_WR: begin
                mem_ctl.dp_we = 1'b1;
                n_best        = best_max;
                if (r_p == '0) begin
                    n_length   = LENGTH_W'(best_max);
                    n_overflow = r_ovf;
                    n_done     = 1'b1;
                    n_count    = '0;
                    n_ovf      = 1'b0;
                    n_state    = S_IDLE;
                end else begin
                    n_p     = r_p - IDX_W'(1);
                    n_state = S_RDP;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy     = (r_state != S_IDLE);
    assign o_done     = r_done;
    assign o_length   = r_length;
    assign o_overflow = r_overflow;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL)
        else $error("element count beyond store depth");

    a_done_after_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == S_WR) && !o_busy)
        else $error("result strobe without a finishing table write");

    a_last_starts_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_last) |=> (o_busy && r_state == S_RDP))
        else $error("closing transfer did not start the table run");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_q <= r_count && r_q > CNT_W'(r_p)))
        else $error("scan index outside stored set");

    a_count_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (r_count == '0 && !r_ovf))
        else $error("set not cleared after result");

endmodule

// ===== rtl/core/lbs_dp_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbs_dp_mem
// element store and dynamic program table, one shared read address,
// registered read data
// ----------------------------------------------------------------------------
module lbs_dp_mem
    import lbs_pkg::*;
#(
    parameter int DEPTH  = LBS_MAX_LEN,
    parameter int DATA_W = LBS_VALUE_BITS,
    parameter int LEN_W  = $clog2(LBS_MAX_LEN + 1)
) (
    input  logic                     i_clk,
    input  t_mem_ctl                 i_ctl,
    input  logic [$clog2(DEPTH)-1:0] i_val_waddr,
    input  logic [DATA_W-1:0]        i_val_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_dp_waddr,
    input  logic [LEN_W-1:0]         i_fall_wdata,
    input  logic [LEN_W-1:0]         i_best_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_val_rdata,
    output logic [LEN_W-1:0]         o_fall_rdata,
    output logic [LEN_W-1:0]         o_best_rdata
);

    logic [DATA_W-1:0]    r_val_mem [DEPTH];
    logic [2*LEN_W-1:0]   r_dp_mem  [DEPTH];
    logic [2*LEN_W-1:0]   r_dp_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.val_we) begin
            r_val_mem[i_val_waddr] <= i_val_wdata;
        end
        o_val_rdata <= r_val_mem[i_raddr];
    end

    // falling length in the upper half, bitonic length in the lower half
    always_ff @(posedge i_clk) begin
        if (i_ctl.dp_we) begin
            r_dp_mem[i_dp_waddr] <= {i_fall_wdata, i_best_wdata};
        end
        r_dp_rdata <= r_dp_mem[i_raddr];
    end

    assign o_fall_rdata = r_dp_rdata[2*LEN_W-1:LEN_W];
    assign o_best_rdata = r_dp_rdata[LEN_W-1:0];

endmodule
